[rtl/krv_pkg.sv]
// Package: constants, types and CRC helper for the key record verifier.
`timescale 1ns / 1ps

package krv_pkg;

  localparam int KEY_BYTES = 32;
  localparam int CRC_SPAN  = 40;
  localparam int HDR_BYTES = 8;
  localparam int REC_LEN   = CRC_SPAN + 4;

  localparam int POS_W     = 6;
  localparam int KEY_AW    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KEY_CNT_W = $clog2(KEY_BYTES + 1);

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAGIC_RESET   = 32'h4B50_534B;
  localparam logic [31:0] VERSION_RESET = 32'h0000_0001;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_HEADER = 2'd1,
    CAUSE_CRC    = 2'd2
  } cause_e;

  typedef enum logic {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic full;
    logic has_pass;
  } jobq_stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

[rtl/key_record_verifier.sv]
// Top level: key record verifier with APB registers, front, queue, back and key buffer.
//
// Channel   Direction  Handshake               Payload
// in        request    in_valid_i/in_stall_o   record_byte_i
// out       result     out_valid_o/out_stall_i key_byte_o, record_valid_o, fail_cause_o,
//                                              last_of_run_o
// cfg       APB write  psel/penable/pready     paddr, pwdata, prdata
//
// One record byte per unstalled cycle; the front's CRC update takes a byte at a time.
// A good record drains 32 key bytes, one per unstalled cycle, via the key RAM read port.
// Key bytes of the next record stall while a pass drain is queued or running.
// The final byte stalls while the two-entry verdict queue is full.
// Reset: asynchronous, active low; key buffer contents are not cleared.
`timescale 1ns / 1ps

module key_record_verifier import krv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  record_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  key_byte_o,
  output logic        record_valid_o,
  output logic [1:0]  fail_cause_o,
  output logic        last_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]       magic_q, version_q;
  logic              cfg_we;
  reg_idx_e          cfg_idx;
  jobq_stat_t        qstat;
  logic              push, pop, head_valid, back_active;
  cause_e            push_cause, head_cause;
  logic              key_we, key_re;
  logic [KEY_AW-1:0] key_waddr, key_raddr;
  logic [7:0]        key_wdata, key_rdata;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_MAGIC:   prdata = magic_q;
      REG_VERSION: prdata = version_q;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RESET;
      version_q <= VERSION_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == REG_MAGIC) begin
        magic_q <= pwdata;
      end else begin
        version_q <= pwdata;
      end
    end
  end

  krv_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .record_byte_i      (record_byte_i),
    .expected_magic_i   (magic_q),
    .expected_version_i (version_q),
    .qstat_i            (qstat),
    .back_active_i      (back_active),
    .push_o             (push),
    .push_cause_o       (push_cause),
    .key_we_o           (key_we),
    .key_waddr_o        (key_waddr),
    .key_wdata_o        (key_wdata)
  );

  krv_job_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cause_i (push_cause),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cause_o (head_cause),
    .stat_o       (qstat)
  );

  krv_ram #(
    .WIDTH (8),
    .DEPTH (KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  krv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_cause_i   (head_cause),
    .pop_o          (pop),
    .active_o       (back_active),
    .key_re_o       (key_re),
    .key_raddr_o    (key_raddr),
    .key_rdata_i    (key_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_byte_o     (key_byte_o),
    .record_valid_o (record_valid_o),
    .fail_cause_o   (fail_cause_o),
    .last_of_run_o  (last_of_run_o)
  );

`ifndef SYNTHESIS
  a_no_key_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(key_we && (back_active || key_re)))
    else $error("key buffer written during drain");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("verdict queue overflow");

  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !record_valid_o) |->
      (last_of_run_o && key_byte_o == 8'd0 && fail_cause_o != CAUSE_NONE))
    else $error("malformed failure result");

  a_pass_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_valid_o) |-> (fail_cause_o == CAUSE_NONE))
    else $error("pass result carries a cause");
`endif

endmodule

[rtl/krv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module krv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/krv_front.sv]
// Front end: header compare, CRC, key buffer writes and job push.
`timescale 1ns / 1ps

module krv_front import krv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        record_byte_i,
  input  logic [31:0]       expected_magic_i,
  input  logic [31:0]       expected_version_i,
  input  jobq_stat_t        qstat_i,
  input  logic              back_active_i,
  output logic              push_o,
  output cause_e            push_cause_o,
  output logic              key_we_o,
  output logic [KEY_AW-1:0] key_waddr_o,
  output logic [7:0]        key_wdata_o
);

  localparam logic [POS_W-1:0] KEY_BASE = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] KEY_END  = POS_W'(HDR_BYTES + KEY_BYTES);
  localparam logic [POS_W-1:0] CRC_BASE = POS_W'(CRC_SPAN);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(REC_LEN - 1);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      crc_fin_q, crc_fin_d;
  logic             hdr_mis_q, hdr_mis_d;
  logic             accept, is_last, in_key, key_busy;
  logic [POS_W-1:0] key_off, crc_off;
  logic [7:0]       hdr_ref;

  assign is_last  = (pos_q == LAST_POS);
  assign in_key   = (pos_q >= KEY_BASE) && (pos_q < KEY_END);
  assign key_busy = qstat_i.has_pass || back_active_i;
  assign in_stall_o = (is_last && qstat_i.full) || (in_key && key_busy);
  assign accept   = in_valid_i && !in_stall_o;
  assign key_off  = pos_q - KEY_BASE;
  assign crc_off  = pos_q - CRC_BASE;
  assign hdr_ref  = (pos_q < POS_W'(4)) ? expected_magic_i[{pos_q[1:0], 3'b000} +: 8]
                                        : expected_version_i[{pos_q[1:0], 3'b000} +: 8];

  assign key_we_o    = accept && in_key;
  assign key_waddr_o = key_off[KEY_AW-1:0];
  assign key_wdata_o = record_byte_i;

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    crc_fin_d    = crc_fin_q;
    hdr_mis_d    = hdr_mis_q;
    push_o       = 1'b0;
    push_cause_o = CAUSE_NONE;
    if (accept) begin
      if (pos_q < KEY_BASE && hdr_ref != record_byte_i) begin
        hdr_mis_d = 1'b1;
      end
      if (pos_q < CRC_BASE) begin
        crc_d = crc_byte(crc_q, record_byte_i);
      end else begin
        crc_fin_d = crc_fin_q | ({24'd0, record_byte_i} << {crc_off[1:0], 3'b000});
      end
      pos_d = pos_q + POS_W'(1);
      if (is_last) begin
        push_o = 1'b1;
        priority if (hdr_mis_d) begin
          push_cause_o = CAUSE_HEADER;
        end else if ((crc_d ^ CRC_ONES) != crc_fin_d) begin
          push_cause_o = CAUSE_CRC;
        end else begin
          push_cause_o = CAUSE_NONE;
        end
        pos_d     = '0;
        crc_d     = CRC_ONES;
        crc_fin_d = '0;
        hdr_mis_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      crc_q     <= CRC_ONES;
      crc_fin_q <= '0;
      hdr_mis_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      crc_fin_q <= crc_fin_d;
      hdr_mis_q <= hdr_mis_d;
    end
  end

endmodule

[rtl/krv_job_queue.sv]
// Two-entry queue of record verdicts between front and back.
`timescale 1ns / 1ps

module krv_job_queue import krv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cause_e     push_cause_i,
  input  logic       pop_i,
  output logic       head_valid_o,
  output cause_e     head_cause_o,
  output jobq_stat_t stat_o
);

  cause_e     ent_q [2];
  logic [1:0] vld_q, vld_d;
  logic       wr_q, rd_q;

  assign head_valid_o    = vld_q[rd_q];
  assign head_cause_o    = ent_q[rd_q];
  assign stat_o.full     = &vld_q;
  assign stat_o.has_pass = (vld_q[0] && ent_q[0] == CAUSE_NONE)
                        || (vld_q[1] && ent_q[1] == CAUSE_NONE);

  always_comb begin
    vld_d = vld_q;
    if (pop_i) begin
      vld_d[rd_q] = 1'b0;
    end
    if (push_i) begin
      vld_d[wr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_cause_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

endmodule

[rtl/krv_back.sv]
// Back end: drains the key buffer or emits a failure result.
`timescale 1ns / 1ps

module krv_back import krv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  cause_e            head_cause_i,
  output logic              pop_o,
  output logic              active_o,
  output logic              key_re_o,
  output logic [KEY_AW-1:0] key_raddr_o,
  input  logic [7:0]        key_rdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        key_byte_o,
  output logic              record_valid_o,
  output logic [1:0]        fail_cause_o,
  output logic              last_of_run_o
);

  localparam logic [KEY_CNT_W-1:0] LAST_IDX = KEY_CNT_W'(KEY_BYTES - 1);

  logic                 job_q, job_d;
  logic [KEY_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pend_q, pend_d;
  logic                 rlast_q, rlast_d;
  logic                 oval_q, oval_d;
  logic [7:0]           okey_q, okey_d;
  logic                 orv_q, orv_d;
  cause_e               ocause_q, ocause_d;
  logic                 olast_q, olast_d;
  logic                 out_free, load, fail_load, issue;

  assign out_free  = !oval_q || !out_stall_i;
  assign load      = pend_q && out_free;
  assign pop_o     = !job_q && !pend_q && head_valid_i
                  && (head_cause_i == CAUSE_NONE || out_free);
  assign fail_load = pop_o && head_cause_i != CAUSE_NONE;
  assign issue     = job_q && (!pend_q || load);
  assign active_o  = job_q;
  assign key_re_o  = issue;
  assign key_raddr_o = cnt_q[KEY_AW-1:0];

  always_comb begin
    job_d   = job_q;
    cnt_d   = cnt_q;
    rlast_d = rlast_q;
    pend_d  = pend_q;
    if (pop_o && head_cause_i == CAUSE_NONE) begin
      job_d = 1'b1;
      cnt_d = '0;
    end
    if (load) begin
      pend_d = 1'b0;
    end
    if (issue) begin
      pend_d  = 1'b1;
      rlast_d = (cnt_q == LAST_IDX);
      cnt_d   = cnt_q + KEY_CNT_W'(1);
      if (cnt_q == LAST_IDX) begin
        job_d = 1'b0;
      end
    end
  end

  always_comb begin
    oval_d   = oval_q && out_stall_i;
    okey_d   = okey_q;
    orv_d    = orv_q;
    ocause_d = ocause_q;
    olast_d  = olast_q;
    priority if (load) begin
      oval_d   = 1'b1;
      okey_d   = key_rdata_i;
      orv_d    = 1'b1;
      ocause_d = CAUSE_NONE;
      olast_d  = rlast_q;
    end else if (fail_load) begin
      oval_d   = 1'b1;
      okey_d   = '0;
      orv_d    = 1'b0;
      ocause_d = head_cause_i;
      olast_d  = 1'b1;
    end else begin
      oval_d   = oval_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q   <= 1'b0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      rlast_q <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      job_q   <= job_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      rlast_q <= rlast_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okey_q   <= okey_d;
    orv_q    <= orv_d;
    ocause_q <= ocause_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o    = oval_q;
  assign key_byte_o     = okey_q;
  assign record_valid_o = orv_q;
  assign fail_cause_o   = ocause_q;
  assign last_of_run_o  = olast_q;

endmodule

[sim/key_record_checker.sv]
// Checker: tracks register writes, predicts key record results and compares them.
`timescale 1ns / 1ps

module key_record_checker import krv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  record_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  key_byte_i,
  input  logic        record_valid_i,
  input  logic [1:0]  fail_cause_i,
  input  logic        last_of_run_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct {
    logic [7:0] key_byte;
    logic       record_valid;
    cause_e     fail_cause;
    logic       last_of_run;
  } key_result_t;

  logic [31:0]      magic_cfg;
  logic [31:0]      version_cfg;
  logic [POS_W-1:0] rec_pos;
  logic [31:0]      crc_run;
  logic [31:0]      crc_stored;
  logic             hdr_bad;
  logic             crc_bad;
  logic [7:0]       key_store [KEY_BYTES];
  key_result_t      key_results_q [$];

  // Reflected CRC-32, one data bit at a time, LSB first.
  function automatic logic [31:0] crc32_shift_in(input logic [31:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  task automatic absorb_record_byte(input logic [7:0] b);
    int          pos;
    key_result_t res;
    pos = rec_pos;
    if (pos < 4) begin
      if (magic_cfg[8*pos +: 8] != b) hdr_bad = 1'b1;
    end else if (pos < HDR_BYTES) begin
      if (version_cfg[8*(pos-4) +: 8] != b) hdr_bad = 1'b1;
    end
    if (pos >= HDR_BYTES && pos < HDR_BYTES + KEY_BYTES) key_store[pos-HDR_BYTES] = b;
    if (pos < CRC_SPAN) crc_run = crc32_shift_in(crc_run, b);
    else if (pos < REC_LEN) crc_stored[8*(pos-CRC_SPAN) +: 8] = b;

    if (pos + 1 < REC_LEN) begin
      rec_pos = POS_W'(pos + 1);
      return;
    end

    crc_bad = ((crc_run ^ CRC_ONES) != crc_stored);
    if (hdr_bad || crc_bad) begin
      res.key_byte     = 8'd0;
      res.record_valid = 1'b0;
      res.fail_cause   = hdr_bad ? CAUSE_HEADER : CAUSE_CRC;
      res.last_of_run  = 1'b1;
      key_results_q.push_back(res);
    end else begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        res.key_byte     = key_store[i];
        res.record_valid = 1'b1;
        res.fail_cause   = CAUSE_NONE;
        res.last_of_run  = (i == KEY_BYTES - 1);
        key_results_q.push_back(res);
      end
    end
    rec_pos    = '0;
    crc_run    = CRC_ONES;
    hdr_bad    = 1'b0;
    crc_stored = '0;
  endtask

  task automatic check_key_result();
    key_result_t want;
    if (key_results_q.size() == 0) begin
      $error("unexpected result: key_byte %0h record_valid %0b fail_cause %0d last_of_run %0b",
             key_byte_i, record_valid_i, fail_cause_i, last_of_run_i);
      error_count_o++;
      return;
    end
    want = key_results_q.pop_front();
    if (key_byte_i !== want.key_byte) begin
      $error("key_byte: expected %0h, actual %0h", want.key_byte, key_byte_i);
      error_count_o++;
    end
    if (record_valid_i !== want.record_valid) begin
      $error("record_valid: expected %0b, actual %0b", want.record_valid, record_valid_i);
      error_count_o++;
    end
    if (fail_cause_i !== want.fail_cause) begin
      $error("fail_cause: expected %0d, actual %0d", want.fail_cause, fail_cause_i);
      error_count_o++;
    end
    if (last_of_run_i !== want.last_of_run) begin
      $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last_of_run_i);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_cfg     = MAGIC_RESET;
      version_cfg   = VERSION_RESET;
      rec_pos       = '0;
      crc_run       = CRC_ONES;
      crc_stored    = '0;
      hdr_bad       = 1'b0;
      crc_bad       = 1'b0;
      error_count_o = 0;
      key_results_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_MAGIC:   magic_cfg = pwdata;
          REG_VERSION: version_cfg = pwdata;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_record_byte(record_byte_i);
      if (out_valid_i && !out_stall_i) check_key_result();
    end
    pending_o = key_results_q.size();
  end

endmodule

[sim/tb_key_record_verifier.sv]
// Testbench top: drives key records and register writes, reports the verdict.
`timescale 1ns / 1ps

module tb_key_record_verifier;
  import krv_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;

  typedef enum {
    REC_GOOD,
    REC_BAD_MAGIC,
    REC_BAD_VERSION,
    REC_BAD_CRC,
    REC_BAD_BOTH,
    REC_NOISE
  } rec_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [7:0]  record_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [7:0]  key_byte_o;
  logic        record_valid_o;
  logic [1:0]  fail_cause_o;
  logic        last_of_run_o;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = 3'd0;
  logic [31:0] pwdata        = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          pending;
  int          cycle_count   = 0;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  logic [31:0] cur_magic     = MAGIC_RESET;
  logic [31:0] cur_version   = VERSION_RESET;

  key_record_verifier DUT (.*);

  key_record_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .record_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .key_byte_i(key_byte_o),
    .record_valid_i(record_valid_o), .fail_cause_i(fail_cause_o),
    .last_of_run_i(last_of_run_o),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .error_count_o(mismatches), .pending_o(pending)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    record_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // fill < 0 gives random key bytes
  task automatic send_record(input rec_kind_e kind, input int fill);
    logic [7:0]  rec [REC_LEN];
    logic [31:0] crc;
    for (int i = 0; i < 4; i++) begin
      rec[i]   = cur_magic[8*i +: 8];
      rec[4+i] = cur_version[8*i +: 8];
    end
    for (int i = HDR_BYTES; i < CRC_SPAN; i++) rec[i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
    if (kind inside {REC_BAD_MAGIC, REC_BAD_BOTH}) rec[$urandom_range(3)] ^= 8'h01 << $urandom_range(7);
    if (kind == REC_BAD_VERSION) rec[$urandom_range(7, 4)] ^= 8'h01 << $urandom_range(7);
    crc = CRC_ONES;
    for (int i = 0; i < CRC_SPAN; i++) crc = crc_byte(crc, rec[i]);
    crc ^= CRC_ONES;
    for (int i = 0; i < 4; i++) rec[CRC_SPAN+i] = crc[8*i +: 8];
    if (kind inside {REC_BAD_CRC, REC_BAD_BOTH}) begin
      rec[$urandom_range(REC_LEN-1, HDR_BYTES)] ^= 8'h01 << $urandom_range(7);
    end
    if (kind == REC_NOISE) begin
      for (int i = 0; i < REC_LEN; i++) rec[i] = 8'($urandom_range(255));
    end
    for (int i = 0; i < REC_LEN; i++) send_byte(rec[i]);
  endtask

  task automatic send_random_record();
    int        r;
    rec_kind_e kind;
    r = $urandom_range(99);
    if (r < 70) kind = REC_GOOD;
    else if (r < 78) kind = REC_BAD_MAGIC;
    else if (r < 84) kind = REC_BAD_VERSION;
    else if (r < 92) kind = REC_BAD_CRC;
    else if (r < 96) kind = REC_BAD_BOTH;
    else kind = REC_NOISE;
    send_record(kind, -1);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [31:0] version);
    write_reg(REG_MAGIC, magic);
    write_reg(REG_VERSION, version);
    cur_magic   = magic;
    cur_version = version;
  endtask

  initial begin
    tx_idle_pct = 22;
    rx_idle_pct = 79;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, all-zero key, CRC failure, header over CRC priority
    send_record(REC_GOOD, 0);
    send_record(REC_BAD_CRC, -1);
    send_record(REC_BAD_BOTH, -1);
    settle();

    tx_idle_pct = 79;
    rx_idle_pct = 22;
    set_config(32'hFFFF_FFFF, 32'h0000_0000);
    send_record(REC_GOOD, 255);
    send_record(REC_BAD_VERSION, -1);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config($urandom, $urandom);
    send_random_record();
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/krv_pkg.sv
rtl/krv_ram.sv
rtl/krv_front.sv
rtl/krv_job_queue.sv
rtl/krv_back.sv
rtl/key_record_verifier.sv
sim/key_record_checker.sv
sim/tb_key_record_verifier.sv
